### hdl/mcvf_pkg.sv
// shared types, constants and the control store of the volume fader
`default_nettype none

package mcvf_pkg;

  localparam int CHANNELS   = 8;
  localparam int MAX_VOLUME = 100;
  localparam int FRAC_BITS  = 16;
  localparam int RESULT_CAP = 24;

  // configuration register index
  localparam int REG_FADEOUT_STOP = 0;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W     = 4;
  localparam int VOL_W    = 7;
  localparam int FRAMES_W = 16;
  localparam int LEVEL_W  = 24;
  localparam int SUM_W    = LEVEL_W + 1;
  localparam int CNT_W    = $clog2(RESULT_CAP + 1);
  localparam int DIV_CNT_W = $clog2(LEVEL_W);
  localparam int PC_W     = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(MAX_VOLUME << FRAC_BITS);
  localparam logic [VOL_W-1:0]   VOL_RESET   = VOL_W'(MAX_VOLUME);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    REQ_PLAY  = 3'd0,
    REQ_FADE  = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_PAUSE = 3'd3,
    REQ_TICK  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CMD_PLAY   = 2'd0,
    CMD_SETVOL = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_PAUSE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EMIT_ERR,
    OP_EMIT_PLAY,
    OP_EMIT_STOP,
    OP_EMIT_PAUSE,
    OP_DIV_START,
    OP_DIV_STORE,
    OP_CH_CLEAR,
    OP_TICK_ADD,
    OP_TICK_END,
    OP_EMIT_FSTOP,
    OP_WRITE_LVL,
    OP_CH_INC,
    OP_FLUSH
  } op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_IF,
    SEQ_MAP
  } seq_t;

  typedef enum logic [2:0] {
    C_NO_INPUT,
    C_DIV_BUSY,
    C_NOT_FADING,
    C_NOT_DONE,
    C_NO_FSTOP,
    C_MORE_CH
  } cond_t;

  typedef struct packed {
    op_t   op;
    seq_t  seq;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic div_busy;
    logic not_fading;
    logic not_done;
    logic no_fstop;
    logic more_ch;
    logic stall;
    pc_t  map_pc;
  } stat_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    cmd_t             cmd;
    logic [VOL_W-1:0] vol;
    logic             loop;
    logic             err;
  } res_t;

  // control store addresses
  localparam pc_t A_IDLE      = 5'd0;
  localparam pc_t A_DISPATCH  = 5'd1;
  localparam pc_t A_ERR       = 5'd2;
  localparam pc_t A_PLAY      = 5'd3;
  localparam pc_t A_STOP      = 5'd4;
  localparam pc_t A_PAUSE     = 5'd5;
  localparam pc_t A_FADE      = 5'd6;
  localparam pc_t A_FADE_WAIT = 5'd7;
  localparam pc_t A_FADE_SET  = 5'd8;
  localparam pc_t A_TICK      = 5'd9;
  localparam pc_t A_CH_TEST   = 5'd10;
  localparam pc_t A_CH_ADD    = 5'd11;
  localparam pc_t A_CH_CHECK  = 5'd12;
  localparam pc_t A_CH_END    = 5'd13;
  localparam pc_t A_CH_STOPQ  = 5'd14;
  localparam pc_t A_CH_STOP   = 5'd15;
  localparam pc_t A_CH_WRITE  = 5'd16;
  localparam pc_t A_CH_NEXT   = 5'd17;
  localparam pc_t A_FLUSH     = 5'd18;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      A_IDLE:      w = '{OP_ACCEPT,     SEQ_IF,   C_NO_INPUT,   A_IDLE};
      A_DISPATCH:  w = '{OP_NONE,       SEQ_MAP,  C_NO_INPUT,   A_IDLE};
      A_ERR:       w = '{OP_EMIT_ERR,   SEQ_JUMP, C_NO_INPUT,   A_FLUSH};
      A_PLAY:      w = '{OP_EMIT_PLAY,  SEQ_JUMP, C_NO_INPUT,   A_FLUSH};
      A_STOP:      w = '{OP_EMIT_STOP,  SEQ_JUMP, C_NO_INPUT,   A_FLUSH};
      A_PAUSE:     w = '{OP_EMIT_PAUSE, SEQ_JUMP, C_NO_INPUT,   A_FLUSH};
      A_FADE:      w = '{OP_DIV_START,  SEQ_NEXT, C_NO_INPUT,   A_IDLE};
      A_FADE_WAIT: w = '{OP_NONE,       SEQ_IF,   C_DIV_BUSY,   A_FADE_WAIT};
      A_FADE_SET:  w = '{OP_DIV_STORE,  SEQ_JUMP, C_NO_INPUT,   A_IDLE};
      A_TICK:      w = '{OP_CH_CLEAR,   SEQ_NEXT, C_NO_INPUT,   A_IDLE};
      A_CH_TEST:   w = '{OP_NONE,       SEQ_IF,   C_NOT_FADING, A_CH_NEXT};
      A_CH_ADD:    w = '{OP_TICK_ADD,   SEQ_NEXT, C_NO_INPUT,   A_IDLE};
      A_CH_CHECK:  w = '{OP_NONE,       SEQ_IF,   C_NOT_DONE,   A_CH_WRITE};
      A_CH_END:    w = '{OP_TICK_END,   SEQ_NEXT, C_NO_INPUT,   A_IDLE};
      A_CH_STOPQ:  w = '{OP_NONE,       SEQ_IF,   C_NO_FSTOP,   A_CH_WRITE};
      A_CH_STOP:   w = '{OP_EMIT_FSTOP, SEQ_NEXT, C_NO_INPUT,   A_IDLE};
      A_CH_WRITE:  w = '{OP_WRITE_LVL,  SEQ_NEXT, C_NO_INPUT,   A_IDLE};
      A_CH_NEXT:   w = '{OP_CH_INC,     SEQ_IF,   C_MORE_CH,    A_CH_TEST};
      A_FLUSH:     w = '{OP_FLUSH,      SEQ_JUMP, C_NO_INPUT,   A_IDLE};
      default:     w = '{OP_NONE,       SEQ_JUMP, C_NO_INPUT,   A_IDLE};
    endcase
    return w;
  endfunction

  // entry point of the program for a request
  function automatic pc_t dispatch(logic [2:0] req, logic [CH_W-1:0] ch);
    pc_t  pc;
    logic bad_ch;
    bad_ch = int'(ch) >= CHANNELS;
    case (req_t'(req))
      REQ_PLAY:  pc = bad_ch ? A_ERR : A_PLAY;
      REQ_FADE:  pc = bad_ch ? A_ERR : A_FADE;
      REQ_STOP:  pc = bad_ch ? A_ERR : A_STOP;
      REQ_PAUSE: pc = bad_ch ? A_ERR : A_PAUSE;
      REQ_TICK:  pc = A_TICK;
      default:   pc = A_IDLE;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

### hdl/mcvf_seq.sv
// microprogram sequencer: step counter, control store and jump logic
`default_nettype none

module mcvf_seq
  import mcvf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stat_t  stat,
  output uword_t      uw
);

  pc_t  pc_r, pc_nxt;
  logic cond_true;

  assign uw = ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      C_NO_INPUT:   cond_true = stat.no_input;
      C_DIV_BUSY:   cond_true = stat.div_busy;
      C_NOT_FADING: cond_true = stat.not_fading;
      C_NOT_DONE:   cond_true = stat.not_done;
      C_NO_FSTOP:   cond_true = stat.no_fstop;
      C_MORE_CH:    cond_true = stat.more_ch;
      default:      cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (stat.stall) begin
      pc_nxt = pc_r;
    end else begin
      unique case (uw.seq)
        SEQ_NEXT: pc_nxt = pc_r + pc_t'(1);
        SEQ_JUMP: pc_nxt = uw.target;
        SEQ_IF:   pc_nxt = cond_true ? uw.target : pc_r + pc_t'(1);
        SEQ_MAP:  pc_nxt = stat.map_pc;
        default:  pc_nxt = A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/mcvf_div.sv
// bit-serial signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module mcvf_div
  import mcvf_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [LEVEL_W-1:0]  dividend,
  input  wire logic [FRAMES_W-1:0]        divisor,
  output logic                            busy,
  output logic signed [LEVEL_W-1:0]       quotient
);

  logic                  busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FRAMES_W-1:0]   rem_r, rem_nxt;
  logic [LEVEL_W-1:0]    quo_r, quo_nxt;
  logic [FRAMES_W-1:0]   dsr_r, dsr_nxt;
  logic                  neg_r, neg_nxt;
  logic [FRAMES_W:0]     shifted;
  logic [FRAMES_W+1:0]   trial;

  assign shifted = {rem_r, quo_r[LEVEL_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      neg_nxt  = dividend[LEVEL_W-1];
      quo_nxt  = dividend[LEVEL_W-1] ? LEVEL_W'(-dividend) : LEVEL_W'(dividend);
    end else if (busy_r) begin
      // restoring step on the magnitude
      if (!trial[FRAMES_W+1]) begin
        rem_nxt = trial[FRAMES_W-1:0];
      end else begin
        rem_nxt = shifted[FRAMES_W-1:0];
      end
      quo_nxt = {quo_r[LEVEL_W-2:0], ~trial[FRAMES_W+1]};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(LEVEL_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

`default_nettype wire

### hdl/mcvf_dp.sv
// datapath: request register, per-channel fade state, level adder and result queue
`default_nettype none

module mcvf_dp
  import mcvf_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire uword_t                     uw,
  input  wire logic                       fadeout_stop,
  // stream input
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,
  input  wire logic [2:0]                 in_tuser,
  // stream output
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [15:0]                     out_tdata,
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast,
  // divider
  output logic                            div_start,
  output logic signed [LEVEL_W-1:0]       div_dividend,
  output logic [FRAMES_W-1:0]             div_divisor,
  input  wire logic                       div_busy,
  input  wire logic signed [LEVEL_W-1:0]  div_quotient,
  output stat_t                           stat
);

  // request fields
  logic [2:0]           req_r;
  logic [CH_W-1:0]      in_ch_r;
  logic [VOL_W-1:0]     vol_r;
  logic [FRAMES_W-1:0]  frames_r;
  logic                 loop_r;
  logic [CH_IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [SUM_W-1:0] lvl_r, lvl_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // channel state
  logic [LEVEL_W-1:0]        cur_r  [CHANNELS];
  logic [VOL_W-1:0]          tgt_r  [CHANNELS];
  logic signed [LEVEL_W-1:0] step_r [CHANNELS];
  logic [CHANNELS-1:0]       fading_r;

  // result queue: one pending beat held back to learn whether it is the last
  res_t p_r, p_nxt;
  logic pv_r, pv_nxt;
  res_t o_r, o_nxt;
  logic ov_r, ov_nxt;
  logic olast_r, olast_nxt;

  logic [LEVEL_W-1:0]        cur_rd;
  logic [VOL_W-1:0]          tgt_rd;
  logic signed [LEVEL_W-1:0] step_rd;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   tgt_lvl;
  logic [VOL_W-1:0]          sum_vol;
  logic [CH_W-1:0]           idx_ch;
  logic                      accept, is_emit, is_flush, cap_full, do_emit;
  logic                      o_busy, stall, act, push, done;
  res_t                      new_res;

  assign cur_rd  = cur_r[idx_r];
  assign tgt_rd  = tgt_r[idx_r];
  assign step_rd = step_r[idx_r];
  assign idx_ch  = CH_W'(idx_r);

  assign sum     = $signed({1'b0, cur_rd}) + $signed({step_rd[LEVEL_W-1], step_rd});
  assign tgt_lvl = $signed({2'b00, tgt_rd, {FRAC_BITS{1'b0}}});

  // clamp to 0..127 before taking the integer part
  always_comb begin
    if (sum[SUM_W-1]) begin
      sum_vol = '0;
    end else if (sum[SUM_W-2]) begin
      sum_vol = '1;
    end else begin
      sum_vol = sum[FRAC_BITS+VOL_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    if (step_rd == '0) begin
      done = lvl_r == tgt_lvl;
    end else if (step_rd[LEVEL_W-1]) begin
      done = lvl_r <= tgt_lvl;
    end else begin
      done = lvl_r >= tgt_lvl;
    end
  end

  assign in_tready = uw.op == OP_ACCEPT;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    is_emit = 1'b1;
    new_res = '{ch: in_ch_r, cmd: CMD_PLAY, vol: '0, loop: 1'b0, err: 1'b0};
    unique case (uw.op)
      OP_EMIT_ERR:   new_res.err = 1'b1;
      OP_EMIT_PLAY: begin
        new_res.vol  = vol_r;
        new_res.loop = loop_r;
      end
      OP_EMIT_STOP:  new_res.cmd = CMD_STOP;
      OP_EMIT_PAUSE: new_res.cmd = CMD_PAUSE;
      OP_TICK_ADD:   new_res = '{ch: idx_ch, cmd: CMD_SETVOL, vol: sum_vol,
                                 loop: 1'b0, err: 1'b0};
      OP_TICK_END:   new_res = '{ch: idx_ch, cmd: CMD_SETVOL, vol: tgt_rd,
                                 loop: 1'b0, err: 1'b0};
      OP_EMIT_FSTOP: new_res = '{ch: idx_ch, cmd: CMD_STOP, vol: '0,
                                 loop: 1'b0, err: 1'b0};
      default:       is_emit = 1'b0;
    endcase
  end

  assign is_flush = uw.op == OP_FLUSH;
  assign cap_full = cnt_r == CNT_W'(RESULT_CAP);
  assign do_emit  = is_emit && !cap_full;
  assign o_busy   = ov_r && !out_tready;
  assign stall    = (do_emit || is_flush) && pv_r && o_busy;
  assign act      = !stall;
  assign push     = act && (do_emit || is_flush) && pv_r;

  always_comb begin
    p_nxt     = p_r;
    pv_nxt    = pv_r;
    o_nxt     = o_r;
    ov_nxt    = ov_r;
    olast_nxt = olast_r;
    cnt_nxt   = cnt_r;
    if (push) begin
      o_nxt     = p_r;
      ov_nxt    = 1'b1;
      olast_nxt = is_flush;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (act && do_emit) begin
      p_nxt   = new_res;
      pv_nxt  = 1'b1;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (act && is_flush) begin
      pv_nxt = 1'b0;
    end
    if (accept) begin
      cnt_nxt = '0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    lvl_nxt = lvl_r;
    if (accept) begin
      idx_nxt = in_tdata[CH_IDX_W-1:0];
    end else if (act) begin
      unique case (uw.op)
        OP_CH_CLEAR: idx_nxt = '0;
        OP_CH_INC:   idx_nxt = idx_r + CH_IDX_W'(1);
        OP_TICK_ADD: lvl_nxt = sum;
        OP_TICK_END: lvl_nxt = tgt_lvl;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    o_r     <= o_nxt;
    olast_r <= olast_nxt;
    idx_r   <= idx_nxt;
    lvl_r   <= lvl_nxt;
    if (accept) begin
      req_r    <= in_tuser;
      in_ch_r  <= in_tdata[CH_W-1:0];
      vol_r    <= in_tdata[CH_W+VOL_W-1:CH_W];
      frames_r <= in_tdata[CH_W+VOL_W+FRAMES_W-1:CH_W+VOL_W];
      loop_r   <= in_tdata[CH_W+VOL_W+FRAMES_W];
    end
  end

  // channel state, all writes at the current channel index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i]  <= LEVEL_RESET;
        tgt_r[i]  <= VOL_RESET;
        step_r[i] <= '0;
      end
      fading_r <= '0;
    end else if (act) begin
      unique case (uw.op)
        OP_EMIT_PLAY: begin
          cur_r[idx_r]    <= {1'b0, vol_r, {FRAC_BITS{1'b0}}};
          fading_r[idx_r] <= 1'b0;
        end
        OP_DIV_START: tgt_r[idx_r] <= vol_r;
        OP_DIV_STORE: begin
          step_r[idx_r]   <= div_quotient;
          fading_r[idx_r] <= 1'b1;
        end
        OP_TICK_END:  fading_r[idx_r] <= 1'b0;
        OP_WRITE_LVL: cur_r[idx_r] <= lvl_r[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign div_start    = act && (uw.op == OP_DIV_START);
  assign div_dividend = $signed({1'b0, vol_r, {FRAC_BITS{1'b0}}} - cur_rd);
  assign div_divisor  = (frames_r == '0) ? FRAMES_W'(1) : frames_r;

  assign stat.no_input   = !in_tvalid;
  assign stat.div_busy   = div_busy;
  assign stat.not_fading = !fading_r[idx_r];
  assign stat.not_done   = !done;
  assign stat.no_fstop   = !(step_rd[LEVEL_W-1] && fadeout_stop);
  assign stat.more_ch    = idx_r != CH_IDX_W'(CHANNELS - 1);
  assign stat.stall      = stall;
  assign stat.map_pc     = dispatch(req_r, in_ch_r);

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0000, o_r.loop, o_r.vol, o_r.ch};
  assign out_tuser  = {o_r.err, o_r.cmd};
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

### hdl/multi_channel_volume_fader_top.sv
// top level of the multi-channel volume fader
`default_nettype none

// Per-channel linear volume fader driven by a small microprogram. Each request
// beat is handled to completion before the next is taken; its command beats
// leave through a one-deep hold and an output register, and the last beat of a
// request carries tlast. A fade waits while the bit-serial divider forms the step one
// quotient bit per cycle (24 bits), and a frame tick has the sequencer walk the channels
// one at a time. No clearing pass is needed after reset. The fadeout_stop register sits
// at byte address 0 of the configuration port; it is to be written only while no request
// is in progress, which the block itself does not enforce.
module multi_channel_volume_fader_top
  import mcvf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // channel[3:0], volume[10:4], fade_frames[26:11],
                                       // loop_play[27]
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  // command stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // out_channel[3:0], out_volume[10:4], out_loop[11]
  output logic [2:0]       out_tuser,  // command[1:0], range_error[2]
  output logic             out_tlast
);

  logic   fadeout_stop_r, fadeout_stop_nxt;
  logic   cfg_wr;
  uword_t uw;
  stat_t  stat;
  logic   div_start, div_busy;
  logic signed [LEVEL_W-1:0] div_dividend, div_quotient;
  logic [FRAMES_W-1:0]       div_divisor;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    fadeout_stop_nxt = fadeout_stop_r;
    if (cfg_wr && (cfg_paddr[2] == 1'(REG_FADEOUT_STOP))) begin
      fadeout_stop_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fadeout_stop_r <= 1'b1;
    end else begin
      fadeout_stop_r <= fadeout_stop_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'(REG_FADEOUT_STOP)) ? {31'd0, fadeout_stop_r}
                                                             : 32'd0;

  mcvf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  mcvf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  mcvf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .uw           (uw),
    .fadeout_stop (fadeout_stop_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_quotient (div_quotient),
    .stat         (stat)
  );

endmodule

`default_nettype wire

### dv/multi_channel_volume_fader_top_test.sv
// self-checking testbench for the multi-channel volume fader top level
module multi_channel_volume_fader_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcvf_pkg::*;

  localparam int LEVEL_TOP     = 127 << FRAC_BITS;
  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    cmd_t             cmd;
    logic [VOL_W-1:0] vol;
    logic             loop;
    logic             err;
    logic             last;
  } fader_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // channel[3:0], volume[10:4], fade_frames[26:11], loop_play[27]
  logic [2:0]  in_tuser = '0;    // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // out_channel[3:0], out_volume[10:4], out_loop[11]
  logic [2:0]  out_tuser;        // command[1:0], range_error[2]
  logic        out_tlast;

  multi_channel_volume_fader_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fader state as the block should hold it
  int               chan_level  [CHANNELS];
  logic [VOL_W-1:0] chan_target [CHANNELS];
  int               chan_step   [CHANNELS];
  bit               chan_fading [CHANNELS];
  bit               fadeout_stop_en;

  fader_cmd_t expected_cmds[$];
  fader_cmd_t new_beats[$];

  int mismatches;
  int requests_sent;
  int ticks_sent;
  int fades_sent;
  int beats_checked;
  int burst_left;

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  function automatic void add_beat(int ch, cmd_t cmd, int vol, bit loop, bit err);
    fader_cmd_t b;
    if (new_beats.size() >= RESULT_CAP) return;
    b.ch   = 4'(ch);
    b.cmd  = cmd;
    b.vol  = 7'(vol);
    b.loop = loop;
    b.err  = err;
    b.last = 1'b0;
    new_beats.push_back(b);
  endfunction

  function automatic void reset_fader_state();
    int i;
    fadeout_stop_en = 1'b1;
    for (i = 0; i < CHANNELS; i++) begin
      chan_level[i]  = MAX_VOLUME << FRAC_BITS;
      chan_target[i] = VOL_W'(MAX_VOLUME);
      chan_step[i]   = 0;
      chan_fading[i] = 1'b0;
    end
  endfunction

  // works out the command beats one request causes and queues them
  function automatic void predict_fader(logic [2:0] req, logic [3:0] ch, logic [6:0] vol,
                                        logic [15:0] frames, logic loop);
    int i;
    int lvl;
    int tgt;
    int stp;
    int shown;
    int div;
    bit done;
    new_beats.delete();
    if (req <= REQ_PAUSE && int'(ch) >= CHANNELS) begin
      add_beat(ch, CMD_PLAY, 0, 1'b0, 1'b1);
    end else begin
      case (req)
        REQ_PLAY: begin
          chan_level[ch]  = int'(vol) << FRAC_BITS;
          chan_fading[ch] = 1'b0;
          add_beat(ch, CMD_PLAY, vol, loop, 1'b0);
        end
        REQ_FADE: begin
          div = (frames == 0) ? 1 : int'(frames);
          chan_target[ch] = vol;
          chan_step[ch]   = ((int'(vol) << FRAC_BITS) - chan_level[ch]) / div;
          chan_fading[ch] = 1'b1;
        end
        REQ_STOP:  add_beat(ch, CMD_STOP, 0, 1'b0, 1'b0);
        REQ_PAUSE: add_beat(ch, CMD_PAUSE, 0, 1'b0, 1'b0);
        REQ_TICK: begin
          for (i = 0; i < CHANNELS; i++) begin
            if (chan_fading[i]) begin
              stp = chan_step[i];
              tgt = int'(chan_target[i]) << FRAC_BITS;
              lvl = chan_level[i] + stp;
              // an overshooting level is clamped before the integer part goes out
              shown = (lvl < 0) ? 0 : ((lvl > LEVEL_TOP) ? LEVEL_TOP : lvl);
              add_beat(i, CMD_SETVOL, shown >>> FRAC_BITS, 1'b0, 1'b0);
              if (stp > 0)      done = (lvl >= tgt);
              else if (stp < 0) done = (lvl <= tgt);
              else              done = (lvl == tgt);
              if (done) begin
                lvl = tgt;
                chan_fading[i] = 1'b0;
                add_beat(i, CMD_SETVOL, chan_target[i], 1'b0, 1'b0);
                if (stp < 0 && fadeout_stop_en) add_beat(i, CMD_STOP, 0, 1'b0, 1'b0);
              end
              chan_level[i] = lvl;
            end
          end
        end
        default: ;
      endcase
    end
    if (new_beats.size() > 0) new_beats[new_beats.size()-1].last = 1'b1;
    foreach (new_beats[k]) expected_cmds.push_back(new_beats[k]);
  endfunction

  // sends one request beat, with bursts and random gaps in between
  task automatic send_request(logic [2:0] req, logic [3:0] ch, logic [6:0] vol,
                              logic [15:0] frames, logic loop);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (idle > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, loop, frames, vol, ch};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    predict_fader(req, ch, vol, frames, loop);
    requests_sent++;
    if (req == REQ_TICK) ticks_sent++;
    if (req == REQ_FADE) fades_sent++;
  endtask

  // input idle, every command beat back, and the block given time to finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fadeout_stop(bit value);
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * REG_FADEOUT_STOP);
    cfg_pwdata  <= {31'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fadeout_stop_en = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[0] !== value)
      report_mismatch($sformatf("fadeout_stop read back: expected %0d actual %0d",
                                value, cfg_prdata[0]));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_request_basics();
    send_request(REQ_PLAY, 4'd0, 7'd0, 16'd0, 1'b1);
    send_request(REQ_PLAY, 4'd7, 7'd127, 16'hFFFF, 1'b0);
    send_request(REQ_STOP, 4'd3, 7'd55, 16'h5A5A, 1'b1);
    send_request(REQ_PAUSE, 4'd5, 7'd100, 16'hA5A5, 1'b1);
    // channels past the last one give a range error
    send_request(REQ_PLAY, 4'd8, 7'd20, 16'd4, 1'b1);
    send_request(REQ_FADE, 4'd15, 7'd0, 16'd1, 1'b0);
    send_request(REQ_STOP, 4'd12, 7'd3, 16'd0, 1'b0);
    send_request(REQ_PAUSE, 4'd9, 7'd90, 16'd9, 1'b1);
    // unknown request codes are dropped
    send_request(3'd5, 4'd1, 7'd1, 16'd1, 1'b0);
    send_request(3'd7, 4'd15, 7'd127, 16'hFFFF, 1'b1);
    // nothing fading yet, so no beat
    send_request(REQ_TICK, 4'd0, 7'd0, 16'd0, 1'b0);
  endtask

  task automatic test_fade_corners();
    send_request(REQ_FADE, 4'd1, 7'd0, 16'd0, 1'b0);    // zero frames: one tick
    send_request(REQ_FADE, 4'd2, 7'd127, 16'd3, 1'b0);  // upward to the top volume
    send_request(REQ_FADE, 4'd0, 7'd0, 16'd5, 1'b0);    // zero step, already at target
    send_request(REQ_FADE, 4'd4, 7'd0, 16'd3, 1'b0);    // downward, overshoots below zero
    repeat (4) send_request(REQ_TICK, 4'd0, 7'd0, 16'd0, 1'b0);
    // a zero step off target never ends until a play cancels it
    send_request(REQ_PLAY, 4'd6, 7'd50, 16'd0, 1'b0);
    send_request(REQ_FADE, 4'd6, 7'd51, 16'hFFFF, 1'b0);
    send_request(REQ_TICK, 4'd6, 7'd0, 16'd0, 1'b0);
    send_request(REQ_FADE, 4'd6, 7'd50, 16'hFFFF, 1'b0);
    repeat (2) send_request(REQ_TICK, 4'd0, 7'd0, 16'd0, 1'b0);
    send_request(REQ_PLAY, 4'd6, 7'd50, 16'd0, 1'b1);
  endtask

  // every channel ends a downward fade on the same tick, with and without stop
  task automatic test_fadeout_stop_setting();
    int setting;
    int i;
    for (setting = 0; setting < 2; setting++) begin
      write_fadeout_stop(setting[0]);
      for (i = 0; i < CHANNELS; i++) send_request(REQ_PLAY, 4'(i), 7'd127, 16'd0, 1'b0);
      for (i = 0; i < CHANNELS; i++) send_request(REQ_FADE, 4'(i), 7'd0, 16'(setting), 1'b0);
      send_request(REQ_TICK, 4'd0, 7'd0, 16'd0, 1'b0);
    end
  endtask

  task automatic test_random_traffic(int count);
    logic [2:0]  req;
    logic [3:0]  ch;
    logic [6:0]  vol;
    logic [15:0] frames;
    int pick;
    int sent;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      req = REQ_TICK;
      else if (pick < 60) req = REQ_FADE;
      else if (pick < 75) req = REQ_PLAY;
      else if (pick < 84) req = REQ_STOP;
      else if (pick < 93) req = REQ_PAUSE;
      else if (pick < 97) req = REQ_PLAY;
      else                req = 3'($urandom_range(5, 7));
      ch  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(CHANNELS, 15))
                                         : 4'($urandom_range(0, CHANNELS - 1));
      vol = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(MAX_VOLUME + 1, 127))
                                        : 7'($urandom_range(0, MAX_VOLUME));
      pick = $urandom_range(0, 99);
      if (pick < 50)      frames = 16'($urandom_range(0, 4));
      else if (pick < 80) frames = 16'($urandom_range(5, 40));
      else if (pick < 95) frames = 16'($urandom_range(0, 65535));
      else                frames = 16'hFFFF;
      send_request(req, ch, vol, frames, 1'($urandom_range(0, 1)));
      if (req <= REQ_TICK) sent++;
    end
  endtask

  task automatic finish_run();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_cmds.size() != 0) begin
      report_mismatch($sformatf("%0d command beats never came", expected_cmds.size()));
      mismatches += expected_cmds.size() - 1;
    end
    $display("covered %0d requests (%0d ticks, %0d fades) and checked %0d command beats",
             requests_sent, ticks_sent, fades_sent, beats_checked);
    $display("fadeout_stop run at both settings; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("multi_channel_volume_fader_top_test OK");
    end else begin
      $display("multi_channel_volume_fader_top_test NOT OK");
    end
    $finish;
  endtask

  // output side stalls: runs of always-ready, random and rotating patterns
  int       rx_mode;
  int       rx_cycles;
  bit [7:0] rx_pattern;

  always @(posedge clk) begin
    if (rx_cycles == 0) begin
      rx_mode    = $urandom_range(0, 2);
      rx_pattern = 8'($urandom) | 8'h01;
      rx_cycles  = $urandom_range(16, 64);
    end
    rx_cycles--;
    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= rx_pattern[0];
    endcase
  end

  always @(posedge clk) begin : check_beats
    fader_cmd_t got;
    fader_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ch   = out_tdata[3:0];
      got.vol  = out_tdata[10:4];
      got.loop = out_tdata[11];
      got.cmd  = cmd_t'(out_tuser[1:0]);
      got.err  = out_tuser[2];
      got.last = out_tlast;
      beats_checked++;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected beat ch %0d cmd %0d vol %0d loop %0d err %0d last %0d",
                                  got.ch, got.cmd, got.vol, got.loop, got.err, got.last));
      end else begin
        want = expected_cmds.pop_front();
        if (got.ch !== want.ch || got.cmd !== want.cmd || got.vol !== want.vol ||
            got.loop !== want.loop || got.err !== want.err || got.last !== want.last)
          report_mismatch($sformatf({"expected ch %0d cmd %0d vol %0d loop %0d err %0d last %0d,",
                                     " actual ch %0d cmd %0d vol %0d loop %0d err %0d last %0d"},
                                    want.ch, want.cmd, want.vol, want.loop, want.err, want.last,
                                    got.ch, got.cmd, got.vol, got.loop, got.err, got.last));
      end
    end
  end

  initial begin
    reset_fader_state();
    mismatches    = 0;
    requests_sent = 0;
    ticks_sent    = 0;
    fades_sent    = 0;
    beats_checked = 0;
    burst_left    = 0;
    rx_cycles     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_basics();
    test_fade_corners();
    test_fadeout_stop_setting();
    test_random_traffic(70);
    write_fadeout_stop(1'b0);
    test_random_traffic(40);
    write_fadeout_stop(1'b1);
    test_random_traffic(30);
    finish_run();
  end

  initial begin
    #4_000_000;
    $display("timeout waiting for the fader");
    $display("multi_channel_volume_fader_top_test NOT OK");
    $finish;
  end

endmodule

### files.f
hdl/mcvf_pkg.sv
hdl/mcvf_seq.sv
hdl/mcvf_div.sv
hdl/mcvf_dp.sv
hdl/multi_channel_volume_fader_top.sv
dv/multi_channel_volume_fader_top_test.sv
